// File: hdl/huffman_code_builder_encoder_top_macros.svh
// Assertion macros used by the checker file hcb_checker.sv.
// No dependencies.
`ifndef HUFFMAN_CODE_BUILDER_ENCODER_TOP_MACROS_SVH
`define HUFFMAN_CODE_BUILDER_ENCODER_TOP_MACROS_SVH
// implication checked every clock, muted in reset
`define HCB_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication failed");
// next-cycle implication
`define HCB_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");
`endif

// File: hdl/hcb_pkg.sv
// Types and constants for the Huffman code builder / encoder.
// No dependencies.
`default_nettype none
package hcb_pkg;
  localparam int ALPHA = 256;
  localparam int NODES = 2 * ALPHA - 1;
  localparam int NODE_W = 9;
  localparam logic [1:0] OP_COUNT = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_ENCODE = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_NOT_BUILT = 2'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
  } in_word_t;

  typedef struct packed {
    logic [31:0] code_bits;
    logic [5:0]  code_length;
    logic        present;
    logic [8:0]  distinct_symbols;
    logic [1:0]  status;
  } out_word_t;
endpackage
`default_nettype wire

// File: hdl/huffman_code_builder_encoder_top.sv
// Huffman code builder / encoder: top level with sequencer and memories.
// Depends on hcb_pkg and hcb_ram.
//
// Usage: one input channel (in_valid/in_ready/in_data) carries a word with
// op and symbol; one output channel (out_valid/out_ready/out_data) returns
// exactly one result word per input word.
// Op 0 counts a byte, op 1 builds the code table, op 2 and op 3 return a
// table entry.
// Sequencing: for count, encode and read the word passes the read states S_RD
// and S_RD2, then S_DO registers the result and raises out_valid. Build clears
// the code table, loads the leaves in a pass over all symbols, then inserts and
// merges nodes for the N present symbols (the single compare unit scans the
// sorted active list, shifts move one entry at a time), walks the tree over the
// internal nodes and finally writes the code of each leaf.
// After reset a clearing pass zeroes the histogram and code table; no word is
// accepted meanwhile.
// One word is in flight at a time. A result stays in the output register
// while the receiver stalls; the next word is accepted only after it is taken.
`default_nettype none
module huffman_code_builder_encoder_top #(
  parameter int SYMBOLS = 256,
  parameter int MAX_CODE_LEN = 32,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hcb_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hcb_pkg::out_word_t     out_data
);
  localparam int NW = hcb_pkg::NODE_W;
  localparam int SW = 8;
  localparam int LW = $clog2(MAX_CODE_LEN + 2);
  localparam int PW = MAX_CODE_LEN + 1;
  localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_RD = 5'd2, S_RD2 = 5'd3,
    S_DO = 5'd4, S_OUT = 5'd5, S_BCLR = 5'd6, S_LEAF = 5'd7, S_LEAF2 = 5'd8,
    S_PSCAN = 5'd9, S_PSCAN2 = 5'd10, S_SHIFT = 5'd11, S_SHIFT2 = 5'd12,
    S_PUT = 5'd13, S_MA = 5'd14, S_MA2 = 5'd15, S_MB = 5'd16, S_MB2 = 5'd17,
    S_POP = 5'd18, S_POP2 = 5'd19, S_MW = 5'd20, S_TR = 5'd21, S_TR2 = 5'd22,
    S_TR3 = 5'd23, S_TW = 5'd24, S_LV = 5'd25, S_LV2 = 5'd26, S_LV3 = 5'd27,
    S_MA3 = 5'd28, S_MB3 = 5'd29, S_PCMP = 5'd30, S_TR4 = 5'd31;

  logic [4:0] state;
  hcb_pkg::in_word_t cur;
  logic [8:0] idx, n, len, leaves, pos, j;
  logic [8:0] na, nb;
  logic [COUNT_WIDTH-1:0] wnew;
  logic [8:0] distinct;
  logic built, ovf;

  // memories
  logic cnt_we; logic [SW-1:0] cnt_wa, cnt_ra; logic [COUNT_WIDTH-1:0] cnt_wd, cnt_rd;
  logic cw_we; logic [SW-1:0] cw_wa, cw_ra; logic [31:0] cw_wd, cw_rd;
  logic cl_we; logic [SW-1:0] cl_wa; logic [5:0] cl_wd, cl_rd;
  logic nw_we; logic [NW-1:0] nw_wa, nw_ra; logic [COUNT_WIDTH-1:0] nw_wd, nw_rd;
  logic nl_we; logic [NW-1:0] nl_wa, nl_ra; logic [2*NW-1:0] nl_wd, nl_rd;
  logic ao_we; logic [NW-1:0] ao_wa, ao_ra; logic [NW-1:0] ao_wd, ao_rd;
  logic pc_we; logic [NW-1:0] pc_wa, pc_ra; logic [PW+LW-1:0] pc_wd, pc_rd;

  hcb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(hcb_pkg::ALPHA)) u_cnt (.clk, .we(cnt_we),
    .waddr(cnt_wa), .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  hcb_ram #(.WIDTH(32), .DEPTH(hcb_pkg::ALPHA)) u_cw (.clk, .we(cw_we),
    .waddr(cw_wa), .wdata(cw_wd), .raddr(cw_ra), .rdata(cw_rd));
  hcb_ram #(.WIDTH(6), .DEPTH(hcb_pkg::ALPHA)) u_cl (.clk, .we(cl_we),
    .waddr(cl_wa), .wdata(cl_wd), .raddr(cw_ra), .rdata(cl_rd));
  hcb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(hcb_pkg::NODES)) u_nw (.clk, .we(nw_we),
    .waddr(nw_wa), .wdata(nw_wd), .raddr(nw_ra), .rdata(nw_rd));
  hcb_ram #(.WIDTH(2*NW), .DEPTH(hcb_pkg::NODES)) u_nl (.clk, .we(nl_we),
    .waddr(nl_wa), .wdata(nl_wd), .raddr(nl_ra), .rdata(nl_rd));
  hcb_ram #(.WIDTH(NW), .DEPTH(hcb_pkg::NODES)) u_ao (.clk, .we(ao_we),
    .waddr(ao_wa), .wdata(ao_wd), .raddr(ao_ra), .rdata(ao_rd));
  hcb_ram #(.WIDTH(PW+LW), .DEPTH(hcb_pkg::NODES)) u_pc (.clk, .we(pc_we),
    .waddr(pc_wa), .wdata(pc_wd), .raddr(pc_ra), .rdata(pc_rd));

  // datapath registers held for the sequencer
  logic [COUNT_WIDTH-1:0] wa_r, key;
  logic [PW-1:0] pcode;
  logic [LW-1:0] plen;
  logic sym_ok;
  assign sym_ok = ({1'b0, cur.symbol} < 9'(SYMBOLS));

  // the shared unit: one weight compare
  logic heavier;
  assign heavier = nw_rd > key;

  // code / path of a tree node: PW bits of code, LW bits of length
  logic [PW-1:0] pc_code; logic [LW-1:0] pc_len;
  assign pc_code = pc_rd[PW+LW-1:LW];
  assign pc_len = pc_rd[LW-1:0];

  always_comb begin
    cnt_we = 1'b0; cnt_wa = idx[SW-1:0]; cnt_wd = '0; cnt_ra = idx[SW-1:0];
    cw_we = 1'b0; cw_wa = idx[SW-1:0]; cw_wd = '0; cw_ra = cur.symbol;
    cl_we = 1'b0; cl_wa = idx[SW-1:0]; cl_wd = '0;
    nw_we = 1'b0; nw_wa = n; nw_wd = key; nw_ra = ao_rd;
    nl_we = 1'b0; nl_wa = n; nl_wd = '0; nl_ra = idx;
    ao_we = 1'b0; ao_wa = j; ao_wd = ao_rd; ao_ra = j;
    pc_we = 1'b0; pc_wa = idx; pc_wd = '0; pc_ra = idx;
    case (state)
      S_CLR, S_BCLR: begin
        cnt_we = (state == S_CLR);
        cw_we = 1'b1; cl_we = 1'b1;
      end
      S_IDLE, S_RD, S_RD2: cnt_ra = cur.symbol;
      S_DO: begin
        cnt_wa = cur.symbol; cnt_ra = cur.symbol;
        cnt_we = (cur.op == hcb_pkg::OP_COUNT) && sym_ok && (cnt_rd != CMAX);
        cnt_wd = cnt_rd + COUNT_WIDTH'(1);
      end
      S_LEAF2: if (cnt_rd != '0 && idx < 9'(SYMBOLS)) begin
        nw_we = 1'b1; nw_wd = cnt_rd;
        nl_we = 1'b1; nl_wd = {{NW{1'b0}}, idx};
      end
      S_PSCAN: ao_ra = pos;
      S_PSCAN2: ao_ra = pos;
      S_SHIFT: ao_ra = j - 9'd1;
      S_SHIFT2: begin ao_we = 1'b1; ao_wa = j; ao_ra = j - 9'd1; end
      S_PUT: begin ao_we = 1'b1; ao_wa = pos; ao_wd = n; end
      S_MA: ao_ra = 9'd0;
      S_MB: ao_ra = 9'd1;
      S_POP: ao_ra = j + 9'd2;
      S_POP2: begin ao_we = 1'b1; ao_wa = j; ao_ra = j + 9'd2; end
      S_MW: begin
        nw_we = 1'b1; nw_wd = wnew;
        nl_we = 1'b1; nl_wd = {na, nb};
      end
      S_TR: begin
        pc_we = (idx == n - 9'd1); pc_wd = '0;
      end
      S_TW: begin
        pc_we = 1'b1; pc_wa = nl_rd[2*NW-1:NW];
        pc_wd = {pcode, plen};
      end
      S_TR3: begin
        pc_we = 1'b1; pc_wa = nl_rd[NW-1:0];
        pc_wd = {pcode | PW'(1), plen};
      end
      S_LV3: if (pc_len <= LW'(MAX_CODE_LEN)) begin
        cw_we = 1'b1; cw_wa = nl_rd[SW-1:0]; cw_wd = 32'(pc_code);
        cl_we = 1'b1; cl_wa = nl_rd[SW-1:0]; cl_wd = 6'(pc_len);
      end
      default: ;
    endcase
  end

  logic [COUNT_WIDTH:0] wsum;
  assign wsum = {1'b0, wa_r} + {1'b0, nw_rd};
  logic place_done;  // 1 while place returns to merging rather than leaf load

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; idx <= '0; distinct <= '0; built <= 1'b0; ovf <= 1'b0;
      out_valid <= 1'b0; place_done <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          idx <= idx + 9'd1;
          if (idx == 9'(hcb_pkg::ALPHA - 1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid) begin cur <= in_data; state <= S_RD; end
        S_RD: state <= S_RD2;
        S_RD2: state <= S_DO;
        S_DO: begin
          out_data.code_bits <= '0; out_data.code_length <= '0;
          out_data.status <= hcb_pkg::ST_OK;
          out_data.present <= sym_ok && cnt_rd != '0;
          out_data.distinct_symbols <= distinct;
          case (cur.op)
            hcb_pkg::OP_COUNT: begin
              if (sym_ok) begin
                if (cnt_rd == '0) begin
                  distinct <= distinct + 9'd1;
                  out_data.distinct_symbols <= distinct + 9'd1;
                end
                out_data.present <= 1'b1;
                built <= 1'b0; ovf <= 1'b0;
              end
              state <= S_OUT;
            end
            hcb_pkg::OP_BUILD: begin
              idx <= '0; built <= 1'b1; ovf <= 1'b0; state <= S_BCLR;
            end
            default: begin
              if (!built) out_data.status <= hcb_pkg::ST_NOT_BUILT;
              else begin
                out_data.status <= ovf ? hcb_pkg::ST_OVERFLOW : hcb_pkg::ST_OK;
                if (sym_ok && cnt_rd != '0) begin
                  out_data.code_bits <= cw_rd;
                  out_data.code_length <= cl_rd;
                end
              end
              state <= S_OUT;
            end
          endcase
          if (cur.op != hcb_pkg::OP_BUILD) out_valid <= 1'b1;
        end
        S_OUT: if (out_valid && out_ready) begin out_valid <= 1'b0; state <= S_IDLE; end
        S_BCLR: begin
          idx <= idx + 9'd1;
          if (idx == 9'(hcb_pkg::ALPHA - 1)) begin
            idx <= '0; n <= '0; len <= '0; state <= S_LEAF;
          end
        end
        S_LEAF: begin
          if (idx == 9'(hcb_pkg::ALPHA)) begin
            leaves <= n;
            if (n == '0) state <= S_OUT; else state <= S_MA;
            if (n == '0) out_valid <= 1'b1;
          end else state <= S_LEAF2;
        end
        S_LEAF2: begin
          if (cnt_rd != '0 && idx < 9'(SYMBOLS)) begin
            key <= cnt_rd; pos <= '0; place_done <= 1'b0; state <= S_PSCAN;
          end else begin
            idx <= idx + 9'd1; state <= S_LEAF;
          end
        end
        // linear scan for first heavier node
        S_PSCAN: begin
          if (pos == len) begin j <= len; state <= S_SHIFT; end
          else state <= S_PSCAN2;
        end
        S_PSCAN2: state <= S_PCMP;
        // weight of ao[pos] is valid now
        S_PCMP: begin
          if (heavier) begin j <= len; state <= S_SHIFT; end
          else begin pos <= pos + 9'd1; state <= S_PSCAN; end
        end
        S_SHIFT: begin
          if (j == pos) state <= S_PUT; else state <= S_SHIFT2;
        end
        S_SHIFT2: begin j <= j - 9'd1; state <= S_SHIFT; end
        S_PUT: begin
          len <= len + 9'd1; n <= n + 9'd1;
          if (place_done) state <= S_MA;
          else begin idx <= idx + 9'd1; state <= S_LEAF; end
        end
        S_MA: begin
          if (len < 9'd2 || n >= 9'(hcb_pkg::NODES)) begin
            idx <= n - 9'd1; state <= S_TR;
          end else state <= S_MA2;
        end
        S_MA2: begin na <= ao_rd; state <= S_MA3; end
        S_MA3: begin wa_r <= nw_rd; state <= S_MB; end
        S_MB: state <= S_MB2;
        S_MB2: begin nb <= ao_rd; state <= S_MB3; end
        S_MB3: begin
          wnew <= wsum[COUNT_WIDTH] ? CMAX : wsum[COUNT_WIDTH-1:0];
          j <= '0; len <= len - 9'd2; state <= S_POP;
        end
        S_POP: begin
          if (j == len) state <= S_MW; else state <= S_POP2;
        end
        S_POP2: begin j <= j + 9'd1; state <= S_POP; end
        S_MW: begin
          key <= wnew; pos <= '0; place_done <= 1'b1; state <= S_PSCAN;
        end
        // tree walk from the root down over the internal nodes
        S_TR: state <= S_TR2;
        S_TR2: begin
          if (idx < leaves) begin idx <= '0; state <= S_LV; end
          else state <= S_TR4;
        end
        S_TR4: begin
          pcode <= {pc_code[PW-2:0], 1'b0};
          plen <= (pc_len == '1) ? pc_len : pc_len + LW'(1);
          state <= S_TW;
        end
        S_TW: state <= S_TR3;
        S_TR3: begin
          if (idx == '0) begin idx <= '0; state <= S_LV; end
          else begin idx <= idx - 9'd1; state <= S_TR; end
        end
        S_LV: begin
          if (idx == leaves) begin
            out_valid <= 1'b1;
            out_data.status <= ovf ? hcb_pkg::ST_OVERFLOW : hcb_pkg::ST_OK;
            state <= S_OUT;
          end else state <= S_LV2;
        end
        S_LV2: state <= S_LV3;
        S_LV3: begin
          if (pc_len > LW'(MAX_CODE_LEN)) begin
            ovf <= 1'b1;
          end
          idx <= idx + 9'd1; state <= S_LV;
        end
        default: ;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);
endmodule
`default_nettype wire

// File: hdl/hcb_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/hcb_checker.sv
// Port-level checker for huffman_code_builder_encoder_top, bound to it.
// Depends on hcb_pkg and the macros header.
`default_nettype none
`include "huffman_code_builder_encoder_top_macros.svh"
module hcb_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire hcb_pkg::out_word_t out_data
);
  // one word in flight: never ready while a result waits
  `HCB_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  // after an accept, in_ready is low in the following cycle
  `HCB_ASSERT_NXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  `HCB_ASSERT_IMP(a_status_code, clk, rst, out_valid, out_data.status <= hcb_pkg::ST_NOT_BUILT)
  `HCB_ASSERT_IMP(a_len_range, clk, rst, out_valid, out_data.code_length <= 6'd32)
endmodule
bind huffman_code_builder_encoder_top hcb_checker u_hcb_checker (.*);
`default_nettype wire

// File: sim/tb_huffman_code_builder_encoder_top.sv
// Testbench for the Huffman code builder / encoder: directed and random words
// checked against a behavioral code builder kept in a small scoreboard class.
// Depends on hcb_pkg and huffman_code_builder_encoder_top.
`timescale 1ns / 100ps
`default_nettype none
module tb_huffman_code_builder_encoder_top;

  class code_scoreboard;
    longint unsigned hist[256];
    int unsigned     n_distinct;
    bit              built, ovf;
    bit [31:0]       tab_code[256];
    int unsigned     tab_len[256];
    hcb_pkg::out_word_t pending[$];
    int              errors;
    int              n_checked;

    function new();
      reset_state();
    endfunction

    function void reset_state();
      foreach (hist[i]) begin
        hist[i] = 0;
        tab_code[i] = 0;
        tab_len[i] = 0;
      end
      n_distinct = 0;
      built = 0;
      ovf = 0;
      errors = 0;
      n_checked = 0;
    endfunction

    function void build_codes();
      longint unsigned wt[hcb_pkg::NODES];
      int unsigned     lnk[hcb_pkg::NODES];
      int unsigned     order[$];
      longint unsigned pcode[hcb_pkg::NODES];
      int unsigned     plen[hcb_pkg::NODES];
      int unsigned     n, leaves, a, b, pos, l, r;
      longint unsigned w;
      n = 0;
      foreach (tab_code[i]) begin
        tab_code[i] = 0;
        tab_len[i] = 0;
      end
      built = 1;
      ovf = 0;
      for (int s = 0; s < 256; s++) begin
        if (hist[s] != 0) begin
          wt[n] = hist[s];
          lnk[n] = s;
          pos = order.size();
          foreach (order[i]) if (wt[order[i]] > wt[n]) begin pos = i; break; end
          order.insert(pos, n);
          n++;
        end
      end
      leaves = n;
      if (leaves == 0) return;
      while (order.size() >= 2) begin
        a = order.pop_front();
        b = order.pop_front();
        w = wt[a] + wt[b];
        if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
        wt[n] = w;
        lnk[n] = (a << 9) | b;
        pos = order.size();
        foreach (order[i]) if (wt[order[i]] > wt[n]) begin pos = i; break; end
        order.insert(pos, n);
        n++;
      end
      pcode[n-1] = 0;
      plen[n-1] = 0;
      for (int k = n - 1; k >= int'(leaves); k--) begin
        l = (lnk[k] >> 9) & 9'h1FF;
        r = lnk[k] & 9'h1FF;
        pcode[l] = pcode[k] << 1;
        plen[l] = plen[k] + 1;
        pcode[r] = (pcode[k] << 1) | 1;
        plen[r] = plen[k] + 1;
      end
      for (int k = 0; k < int'(leaves); k++) begin
        if (plen[k] > 32) ovf = 1;
        else begin
          tab_code[lnk[k] & 8'hFF] = pcode[k][31:0];
          tab_len[lnk[k] & 8'hFF] = plen[k];
        end
      end
    endfunction

    function void note_word(hcb_pkg::in_word_t w);
      hcb_pkg::out_word_t e;
      e = '0;
      case (w.op)
        hcb_pkg::OP_COUNT: begin
          if (hist[w.symbol] == 0) n_distinct++;
          if (hist[w.symbol] < 64'hFFFF_FFFF) hist[w.symbol]++;
          built = 0;
          ovf = 0;
          e.status = hcb_pkg::ST_OK;
        end
        hcb_pkg::OP_BUILD: begin
          build_codes();
          e.status = ovf ? hcb_pkg::ST_OVERFLOW : hcb_pkg::ST_OK;
        end
        default: begin
          if (!built) e.status = hcb_pkg::ST_NOT_BUILT;
          else begin
            e.status = ovf ? hcb_pkg::ST_OVERFLOW : hcb_pkg::ST_OK;
            if (hist[w.symbol] != 0) begin
              e.code_bits = tab_code[w.symbol];
              e.code_length = tab_len[w.symbol][5:0];
            end
          end
        end
      endcase
      e.present = hist[w.symbol] != 0;
      e.distinct_symbols = n_distinct[8:0];
      pending.push_back(e);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
      errors++;
      if (errors <= 40)
        $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
    endtask

    task check_word(hcb_pkg::out_word_t g);
      hcb_pkg::out_word_t e;
      n_checked++;
      if (pending.size() == 0) begin
        report("unexpected word", 64'(g), 0);
        return;
      end
      e = pending.pop_front();
      if (g.code_bits !== e.code_bits) report("code_bits", g.code_bits, e.code_bits);
      if (g.code_length !== e.code_length) report("code_length", g.code_length, e.code_length);
      if (g.present !== e.present) report("present", g.present, e.present);
      if (g.distinct_symbols !== e.distinct_symbols)
        report("distinct_symbols", g.distinct_symbols, e.distinct_symbols);
      if (g.status !== e.status) report("status", g.status, e.status);
    endtask
  endclass

  logic      clk, rst;
  logic      in_valid, in_ready, out_valid, out_ready;
  hcb_pkg::in_word_t  in_data;
  hcb_pkg::out_word_t out_data;
  code_scoreboard sb;
  bit        calm;      // no idling on either side
  int        n_sent;
  int        n_builds;

  huffman_code_builder_encoder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, checks every taken word
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) sb.check_word(out_data);
      out_ready <= calm || ($urandom_range(99) >= 8);
    end
  end

  // valid stays up between back-to-back words; it drops only while idling or draining
  task automatic send_word(logic [1:0] op, logic [7:0] sym);
    hcb_pkg::in_word_t w;
    while (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    w.op = op;
    w.symbol = sym;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(w);
    n_sent++;
    if (op == hcb_pkg::OP_BUILD) n_builds++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // well-formed phase: count a stream, skewed when skew is set, build, look up
  task automatic random_phase(int n_counts, int alpha_hi, bit skew);
    logic [7:0] s;
    for (int i = 0; i < n_counts; i++) begin
      s = skew ? 8'($urandom_range($urandom_range(alpha_hi), 0)) : 8'($urandom_range(alpha_hi));
      if ($urandom_range(99) < 5) send_word(2'($urandom_range(3)), 8'($urandom));
      else send_word(hcb_pkg::OP_COUNT, s);
    end
    send_word(hcb_pkg::OP_BUILD, 8'($urandom));
    for (int i = 0; i < 20; i++)
      send_word($urandom_range(1) ? hcb_pkg::OP_ENCODE : hcb_pkg::OP_READ,
                $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(alpha_hi)));
  endtask

  initial begin
    sb = new();
    calm = 0;
    n_sent = 0;
    n_builds = 0;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: unbuilt reads, empty build, single symbol, three symbols
    send_word(hcb_pkg::OP_ENCODE, 8'h00);
    send_word(hcb_pkg::OP_READ, 8'hFF);
    send_word(hcb_pkg::OP_BUILD, 8'h00);
    send_word(hcb_pkg::OP_ENCODE, 8'h00);
    send_word(hcb_pkg::OP_COUNT, 8'hFF);
    send_word(hcb_pkg::OP_READ, 8'hFF);
    send_word(hcb_pkg::OP_BUILD, 8'hAA);
    send_word(hcb_pkg::OP_ENCODE, 8'hFF);
    send_word(hcb_pkg::OP_COUNT, 8'h00);
    send_word(hcb_pkg::OP_COUNT, 8'h55);
    send_word(hcb_pkg::OP_BUILD, 8'h55);
    send_word(hcb_pkg::OP_ENCODE, 8'h00);
    send_word(hcb_pkg::OP_READ, 8'h55);
    send_word(hcb_pkg::OP_READ, 8'h12);
    // sender hold-off until all results are in
    drain();
    repeat (50) @(posedge clk);

    calm = 1;
    begin
      int fib[10];
      fib[0] = 1; fib[1] = 1;
      for (int i = 2; i < 10; i++) fib[i] = fib[i-1] + fib[i-2];
      // maximally skewed tree: weights 1,1,2,3,5... up to 55 over 10 symbols
      for (int i = 0; i < 10; i++)
        for (int j = 0; j < fib[i]; j++) send_word(hcb_pkg::OP_COUNT, 8'(100 + i));
    end
    calm = 0;
    send_word(hcb_pkg::OP_BUILD, 8'h00);
    send_word(hcb_pkg::OP_ENCODE, 8'd100);
    send_word(hcb_pkg::OP_READ, 8'd109);
    drain();
    repeat (50) @(posedge clk);

    // random well-formed phases
    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      random_phase($urandom_range(30, 50), p == 5 ? 255 : $urandom_range(3, 40), p[0]);
    end
    calm = 0;
    // every byte present: largest build
    for (int s = 0; s < 256; s++) send_word(hcb_pkg::OP_COUNT, 8'(s));
    send_word(hcb_pkg::OP_BUILD, 8'h00);
    for (int i = 0; i < 30; i++) send_word(hcb_pkg::OP_ENCODE, 8'($urandom));

    drain();
    repeat (100) @(posedge clk);
    $display("Covered %0d words, %0d builds, incl. unbuilt, empty, single-symbol, skewed.",
             n_sent, n_builds);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/hcb_pkg.sv
hdl/hcb_ram.sv
hdl/huffman_code_builder_encoder_top.sv
hdl/hcb_checker.sv
sim/tb_huffman_code_builder_encoder_top.sv
